### rtl/ptd_pkg.sv
package ptd_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int KEY_W   = 64;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 22;
  localparam int TOTAL_W = 23;
  localparam int OVH_W   = 8;
  localparam int AGE_W   = 16;
  localparam int STAMP_W = 48;
  localparam int STAT_W  = 2;

  localparam logic [OVH_W-1:0] OVH_RESET = OVH_W'(1);

  typedef enum logic {
    REQ_ADD      = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED      = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               commit;
    logic [BURST_W-1:0] burst;
  } tim_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [TIME_W-1:0]  response;
    logic [TIME_W-1:0]  busy_time;
    logic [TOTAL_W-1:0] elapsed_total;
  } tim_res_t;

endpackage

### rtl/ptd_req_if.sv
interface ptd_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ptd_pkg::KEY_W-1:0]    task_key;
  logic [ptd_pkg::PRIO_W-1:0]   task_priority;
  logic [ptd_pkg::BURST_W-1:0]  task_burst;

  modport source (
    output valid, req_type, task_key, task_priority, task_burst,
    input  ready
  );

  modport sink (
    input  valid, req_type, task_key, task_priority, task_burst,
    output ready
  );
endinterface

### rtl/ptd_res_if.sv
interface ptd_res_if;
  logic                         valid;
  logic                         ready;
  logic [ptd_pkg::STAT_W-1:0]   status;
  logic [ptd_pkg::KEY_W-1:0]    chosen_key;
  logic [ptd_pkg::TIME_W-1:0]   turnaround;
  logic [ptd_pkg::TIME_W-1:0]   waiting;
  logic [ptd_pkg::TIME_W-1:0]   response;
  logic [ptd_pkg::TIME_W-1:0]   busy_time;
  logic [ptd_pkg::TOTAL_W-1:0]  elapsed_total;

  modport source (
    output valid, status, chosen_key, turnaround, waiting, response, busy_time,
           elapsed_total,
    input  ready
  );

  modport sink (
    input  valid, status, chosen_key, turnaround, waiting, response, busy_time,
           elapsed_total,
    output ready
  );
endinterface

### rtl/ptd_timing.sv
module ptd_timing (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ptd_pkg::OVH_W-1:0]   overhead,
  input  ptd_pkg::tim_cmd_t           cmd,
  output ptd_pkg::tim_res_t           res
);
  import ptd_pkg::*;

  logic [TIME_W-1:0]  clk_r, clk_nxt;
  logic [TOTAL_W-1:0] ovh_r, ovh_nxt;
  logic               any_r;
  logic [TIME_W-1:0]  resp_r;
  logic [BURST_W-1:0] burst_r;
  logic [TIME_W:0]    clk_sum;
  logic [TOTAL_W:0]   ovh_sum;
  logic [TOTAL_W:0]   tot_sum;

  always_comb begin
    clk_sum = {1'b0, clk_r} + (TIME_W+1)'(cmd.burst);
    clk_nxt = clk_sum[TIME_W] ? '1 : clk_sum[TIME_W-1:0];
    ovh_sum = {1'b0, ovh_r} + (TOTAL_W+1)'(overhead);
    if (any_r) begin
      ovh_nxt = ovh_sum[TOTAL_W] ? '1 : ovh_sum[TOTAL_W-1:0];
    end else begin
      ovh_nxt = ovh_r;
    end
    tot_sum = (TOTAL_W+1)'(clk_r) + {1'b0, ovh_r};

    res.turnaround    = clk_r;
    res.busy_time     = clk_r;
    res.response      = resp_r;
    res.waiting       = (clk_r >= TIME_W'(burst_r)) ? clk_r - TIME_W'(burst_r) : '0;
    res.elapsed_total = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_r <= '0;
      ovh_r <= '0;
      any_r <= 1'b0;
    end else if (cmd.commit) begin
      clk_r <= clk_nxt;
      ovh_r <= ovh_nxt;
      any_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      resp_r  <= clk_r;
      burst_r <= cmd.burst;
    end
  end

endmodule

### rtl/priority_task_dispatcher.sv
// Non-preemptive priority dispatcher with a table of TABLE_DEPTH tasks.
// in_req  : one beat per request. req_type add stores key, priority and burst
//           in the lowest free slot; dispatch removes the best task (highest
//           priority, then smaller key, then most recently added).
// out_res : one beat per request: status, and for a dispatch the key and the
//           turnaround, waiting, response, busy and total times.
// cfg_we/cfg_wdata set the per-switch dispatch overhead (reset value 1).
// Every request walks the whole table through the single read port of the
// entry memory, one entry per cycle, then passes the commit and emit states
// before the result beat is offered.
// Requests are handled one at a time; in_req.ready is high only while idle.
// A finished result waits in the output register; the next request may be
// accepted and scanned meanwhile, and it holds before its own result until
// that register is free.
// After reset the entry memory is cleared, one entry per cycle, with
// in_req.ready low. Time counters start at zero.
module priority_task_dispatcher #(
  parameter int TABLE_DEPTH = ptd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ptd_req_if.sink                     in_req,
  ptd_res_if.source                   out_res,
  input  logic                        cfg_we,
  input  logic [ptd_pkg::OVH_W-1:0]   cfg_wdata
);
  import ptd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               accept;
  logic               load_out;

  req_t               req_r;
  logic [KEY_W-1:0]   in_key_r;
  logic [PRIO_W-1:0]  in_prio_r;
  logic [BURST_W-1:0] in_burst_r;
  logic [OVH_W-1:0]   ovh_cfg_r;
  logic [STAMP_W-1:0] add_cnt_r;

  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_at_r;
  logic [STAMP_W-1:0] age_diff;
  logic [AGE_W-1:0]   age_cur;

  logic               cand_pv_r;
  logic               cand_ok_r;
  logic [KEY_W-1:0]   cand_key_r;
  logic [PRIO_W-1:0]  cand_prio_r;
  logic [BURST_W-1:0] cand_burst_r;
  logic [AGE_W-1:0]   cand_age_r;
  logic [IDX_W-1:0]   cand_at_r;
  logic               cand_wins;

  logic               best_ok_r;
  logic [KEY_W-1:0]   best_key_r;
  logic [PRIO_W-1:0]  best_prio_r;
  logic [BURST_W-1:0] best_burst_r;
  logic [AGE_W-1:0]   best_age_r;
  logic [IDX_W-1:0]   best_at_r;

  logic               free_ok_r;
  logic [IDX_W-1:0]   free_at_r;

  tim_cmd_t           tim_cmd;
  tim_res_t           tim_res;
  status_t            res_status;
  logic               res_disp;

  logic               out_vld_r;
  status_t            out_status_r;
  logic [KEY_W-1:0]   out_key_r;
  logic [TIME_W-1:0]  out_turn_r;
  logic [TIME_W-1:0]  out_wait_r;
  logic [TIME_W-1:0]  out_resp_r;
  logic [TIME_W-1:0]  out_busy_r;
  logic [TOTAL_W-1:0] out_total_r;

  ptd_timing u_timing (
    .clk      (clk),
    .rst_n    (rst_n),
    .overhead (ovh_cfg_r),
    .cmd      (tim_cmd),
    .res      (tim_res)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    load_out       = 1'b0;
    tim_cmd.commit = 1'b0;
    tim_cmd.burst  = best_burst_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = ptr_r[IDX_W-1:0];
        if (ptr_r == LAST_C) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          ptr_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ptr_r != DEPTH_C) begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_r + CNT_W'(1);
        end else if (!rd_vld_r && !cand_pv_r) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (req_r == REQ_ADD) begin
          if (free_ok_r) begin
            mem_we       = 1'b1;
            mem_wa       = free_at_r;
            mem_wd.valid = 1'b1;
            mem_wd.key   = in_key_r;
            mem_wd.prio  = in_prio_r;
            mem_wd.burst = in_burst_r;
            mem_wd.stamp = add_cnt_r + STAMP_W'(1);
          end
        end else if (best_ok_r) begin
          mem_we         = 1'b1;
          mem_wa         = best_at_r;
          tim_cmd.commit = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_r || out_res.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_addr = rd_en ? ptr_r[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      ptr_r     <= '0;
      ovh_cfg_r <= OVH_RESET;
      add_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_we) begin
        ovh_cfg_r <= cfg_wdata;
      end
      if (state_r == S_COMMIT && req_r == REQ_ADD && free_ok_r) begin
        add_cnt_r <= add_cnt_r + STAMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= req_t'(in_req.req_type);
      in_key_r   <= in_req.task_key;
      in_prio_r  <= in_req.task_priority;
      in_burst_r <= in_req.task_burst;
    end
  end

  // age saturates once the stamp is 2^AGE_W or more adds old
  always_comb begin
    age_diff = add_cnt_r - rd_q.stamp;
    age_cur  = (|age_diff[STAMP_W-1:AGE_W]) ? '1 : age_diff[AGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      cand_pv_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_en;
      cand_pv_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_at_r      <= rd_addr;
    cand_ok_r    <= rd_q.valid;
    cand_key_r   <= rd_q.key;
    cand_prio_r  <= rd_q.prio;
    cand_burst_r <= rd_q.burst;
    cand_age_r   <= age_cur;
    cand_at_r    <= rd_at_r;
  end

  always_comb begin
    cand_wins = !best_ok_r
             || (cand_prio_r > best_prio_r)
             || ((cand_prio_r == best_prio_r)
                 && ((cand_key_r < best_key_r)
                     || ((cand_key_r == best_key_r) && (cand_age_r < best_age_r))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (accept) begin
      best_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else begin
      if (cand_pv_r && cand_ok_r && req_r == REQ_DISPATCH && cand_wins) begin
        best_ok_r <= 1'b1;
      end
      if (rd_vld_r && !rd_q.valid && req_r == REQ_ADD) begin
        free_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_pv_r && cand_ok_r && req_r == REQ_DISPATCH && cand_wins) begin
      best_key_r   <= cand_key_r;
      best_prio_r  <= cand_prio_r;
      best_burst_r <= cand_burst_r;
      best_age_r   <= cand_age_r;
      best_at_r    <= cand_at_r;
    end
    if (rd_vld_r && !rd_q.valid && req_r == REQ_ADD && !free_ok_r) begin
      free_at_r <= rd_at_r;
    end
  end

  always_comb begin
    if (req_r == REQ_ADD) begin
      res_status = free_ok_r ? ST_ADDED : ST_FULL;
      res_disp   = 1'b0;
    end else begin
      res_status = best_ok_r ? ST_DISPATCHED : ST_EMPTY;
      res_disp   = best_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_key_r    <= res_disp ? best_key_r            : '0;
      out_turn_r   <= res_disp ? tim_res.turnaround    : '0;
      out_wait_r   <= res_disp ? tim_res.waiting       : '0;
      out_resp_r   <= res_disp ? tim_res.response      : '0;
      out_busy_r   <= res_disp ? tim_res.busy_time     : '0;
      out_total_r  <= res_disp ? tim_res.elapsed_total : '0;
    end
  end

  assign out_res.valid         = out_vld_r;
  assign out_res.status        = out_status_r;
  assign out_res.chosen_key    = out_key_r;
  assign out_res.turnaround    = out_turn_r;
  assign out_res.waiting       = out_wait_r;
  assign out_res.response      = out_resp_r;
  assign out_res.busy_time     = out_busy_r;
  assign out_res.elapsed_total = out_total_r;

`ifndef ASSERT_OFF
  a_nodisp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status != ST_DISPATCHED)
      |-> (out_res.chosen_key == '0 && out_res.elapsed_total == '0))
    else $error("non-dispatch result carries payload");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_COMMIT))
    else $error("entry memory written outside clear or commit");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> (!rd_vld_r && !cand_pv_r))
    else $error("scan pipeline busy while idle");

  a_busy_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (tim_res.busy_time >= $past(tim_res.busy_time)))
    else $error("busy time went backwards");
`endif

endmodule

### tb/sv/ptd_dispatch_checker.sv
module ptd_dispatch_checker import ptd_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ptd_req_if               req_mon,
  ptd_res_if               res_mon,
  input  logic             cfg_we,
  input  logic [OVH_W-1:0] cfg_wdata,
  output int               outstanding,
  output int               fail_count
);

  localparam longint unsigned TIME_SAT  = (64'd1 << TIME_W) - 1;
  localparam longint unsigned TOTAL_SAT = (64'd1 << TOTAL_W) - 1;
  localparam int unsigned     AGE_SAT   = (1 << AGE_W) - 1;

  typedef struct {
    bit                 used;
    logic [KEY_W-1:0]   key;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    int unsigned        age;
  } task_slot_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [TIME_W-1:0]  response;
    logic [TIME_W-1:0]  busy_time;
    logic [TOTAL_W-1:0] elapsed_total;
  } sched_result_t;

  task_slot_t      slots[TABLE_DEPTH];
  logic [OVH_W-1:0] overhead;
  longint unsigned busy_clock;
  longint unsigned overhead_total;
  bit              served_any;
  sched_result_t   expected_q[$];
  int              failures;

  function automatic bit outranks(int a, int b);
    if (slots[a].prio != slots[b].prio) return slots[a].prio > slots[b].prio;
    if (slots[a].key != slots[b].key) return slots[a].key < slots[b].key;
    return slots[a].age < slots[b].age;
  endfunction

  function automatic sched_result_t serve_request(req_t kind, logic [KEY_W-1:0] key,
                                                  logic [PRIO_W-1:0] prio,
                                                  logic [BURST_W-1:0] burst);
    sched_result_t   r;
    int              pick;
    int              i;
    longint unsigned total;
    longint unsigned run;
    r = '0;
    pick = -1;
    if (kind == REQ_ADD) begin
      for (i = 0; i < TABLE_DEPTH; i++)
        if (!slots[i].used && pick < 0) pick = i;
      if (pick < 0) begin
        r.status = ST_FULL;
        return r;
      end
      for (i = 0; i < TABLE_DEPTH; i++)
        if (slots[i].used && slots[i].age < AGE_SAT) slots[i].age++;
      slots[pick].used  = 1'b1;
      slots[pick].key   = key;
      slots[pick].prio  = prio;
      slots[pick].burst = burst;
      slots[pick].age   = 0;
      r.status = ST_ADDED;
      return r;
    end
    for (i = 0; i < TABLE_DEPTH; i++)
      if (slots[i].used && (pick < 0 || outranks(i, pick))) pick = i;
    if (pick < 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    slots[pick].used = 1'b0;
    run = slots[pick].burst;
    if (served_any) begin
      overhead_total += overhead;
      if (overhead_total > TOTAL_SAT) overhead_total = TOTAL_SAT;
    end
    served_any = 1'b1;
    r.response = busy_clock[TIME_W-1:0];
    busy_clock += run;
    if (busy_clock > TIME_SAT) busy_clock = TIME_SAT;
    total = busy_clock + overhead_total;
    if (total > TOTAL_SAT) total = TOTAL_SAT;
    r.status        = ST_DISPATCHED;
    r.key           = slots[pick].key;
    r.turnaround    = busy_clock[TIME_W-1:0];
    r.waiting       = (busy_clock >= run) ? TIME_W'(busy_clock - run) : '0;
    r.busy_time     = busy_clock[TIME_W-1:0];
    r.elapsed_total = total[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic string describe(sched_result_t r);
    return $sformatf("status %0d key %h turnaround %0d waiting %0d response %0d busy %0d total %0d",
                     r.status, r.key, r.turnaround, r.waiting, r.response, r.busy_time,
                     r.elapsed_total);
  endfunction

  always @(posedge clk) begin
    sched_result_t seen;
    sched_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slots[i].used = 1'b0;
      overhead       = OVH_RESET;
      busy_clock     = 0;
      overhead_total = 0;
      served_any     = 1'b0;
      failures       = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) overhead = cfg_wdata;
      if (res_mon.valid && res_mon.ready) begin
        seen.status        = status_t'(res_mon.status);
        seen.key           = res_mon.chosen_key;
        seen.turnaround    = res_mon.turnaround;
        seen.waiting       = res_mon.waiting;
        seen.response      = res_mon.response;
        seen.busy_time     = res_mon.busy_time;
        seen.elapsed_total = res_mon.elapsed_total;
        if (expected_q.size() == 0) begin
          if (failures < 10) $display("unexpected result beat: %s", describe(seen));
          failures++;
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            if (failures < 10) begin
              $display("result mismatch, expected: %s", describe(want));
              $display("                   actual: %s", describe(seen));
            end
            failures++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(serve_request(req_t'(req_mon.req_type), req_mon.task_key,
                                           req_mon.task_priority, req_mon.task_burst));
    end
    outstanding <= expected_q.size();
    fail_count  <= failures;
  end

endmodule

### tb/sv/tb_priority_task_dispatcher.sv
module tb_priority_task_dispatcher;
  import ptd_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int ITEM_LATENCY = TABLE_DEPTH + 5;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 86;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [OVH_W-1:0] cfg_wdata;
  int               outstanding;
  int               fail_count;
  int               results_seen;
  int               burst_left;
  bit               draining;

  ptd_req_if in_req();
  ptd_res_if out_res();

  priority_task_dispatcher #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ptd_dispatch_checker #(.TABLE_DEPTH(TABLE_DEPTH)) dispatch_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_req),
    .res_mon     (out_res),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      results_seen <= 0;
    end else if (out_res.valid && out_res.ready) begin
      results_seen <= results_seen + 1;
    end
  end

  task automatic send_beat(req_t kind, logic [KEY_W-1:0] key, logic [PRIO_W-1:0] prio,
                           logic [BURST_W-1:0] burst);
    if (burst_left == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_req.valid         <= 1'b1;
    in_req.req_type      <= kind;
    in_req.task_key      <= key;
    in_req.task_priority <= prio;
    in_req.task_burst    <= burst;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic send_dispatch();
    send_beat(REQ_DISPATCH, {$urandom, $urandom}, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_random(int add_pct);
    logic [KEY_W-1:0]   key;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    key   = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                        : {"JOB", 8'($urandom_range(48, 53)), 32'h0};
    prio  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    burst = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
    send_beat(($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_DISPATCH, key, prio, burst);
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    burst_left = 0;
    draining = 1'b1;
    do @(posedge clk); while (outstanding != 0);
    draining = 1'b0;
  endtask

  task automatic write_overhead(logic [OVH_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int add_pct[PHASES];
    add_pct = '{60, 92, 25, 55, 95, 20, 50, 70};
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_req.valid         <= 1'b0;
    in_req.req_type      <= REQ_ADD;
    in_req.task_key      <= '0;
    in_req.task_priority <= '0;
    in_req.task_burst    <= '0;
    burst_left = 0;
    draining = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_dispatch();
    send_beat(REQ_ADD, '0, 8'd0, 16'd0);
    send_beat(REQ_ADD, '1, 8'd255, 16'hFFFF);
    send_beat(REQ_ADD, {"ALPHA", 24'h0}, 8'd255, 16'd1);
    send_beat(REQ_ADD, {"ALPHA", 24'h0}, 8'd255, 16'd2);
    send_beat(REQ_ADD, {"BETA", 32'h0}, 8'd7, 16'd300);
    send_beat(REQ_ADD, {16{4'h5}}, 8'hAA, 16'h5555);
    send_beat(REQ_ADD, {16{4'hA}}, 8'h55, 16'hAAAA);
    send_beat(REQ_ADD, {"ALPHA", 24'h0}, 8'd128, 16'd10);
    repeat (9) send_dispatch();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_overhead((p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom));
      repeat (PHASE_ITEMS) send_random(add_pct[p]);
      wait_drained();
    end

    repeat (ITEM_LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_priority_task_dispatcher passed");
    end else begin
      $display("tb_priority_task_dispatcher failed");
    end
    $finish;
  end

  initial begin : result_sink
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    forever begin
      if (outstanding != 0 && !draining &&
          ((!held && results_seen >= 40) || $urandom_range(0, 39) == 0)) begin
        out_res.ready <= 1'b0;
        repeat (held ? $urandom_range(150, 400) : 600) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 200);
      repeat (span) begin
        case (mode)
          0: begin
            out_res.ready <= 1'b1;
          end
          1: begin
            out_res.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_res.ready <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            out_res.ready <= ($urandom_range(0, 7) == 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("tb_priority_task_dispatcher failed");
    $finish;
  end

endmodule
